// File: design/inlier_gated_line_fit_unit_macros.svh
// assertion macros shared by the inlier gated line fit design files
// no dependencies; included by files that carry concurrent assertions
`ifndef INLIER_GATED_LINE_FIT_UNIT_MACROS_SVH
`define INLIER_GATED_LINE_FIT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ILF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ILF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ilf_pkg.sv
// shared types and constants of the inlier gated line fit unit
// no dependencies; used by the top level, controller, datapath and divider
package ilf_pkg;

  localparam int LINE_W     = 32;   // Q16.16 line fields
  localparam int PT_W       = 16;   // Q4.12 point fields
  localparam int TOL_W      = 15;
  localparam int CNT_OUT_W  = 11;
  localparam int PAX_W      = 48;   // slope times x
  localparam int SQ_PT_W    = 32;   // x*x and x*y
  localparam int RES_W      = 50;   // residual in Q.28
  localparam int FRAC_SHIFT = 16;
  localparam int ICPT_SHIFT = 12;
  localparam int N_SHIFT    = 28;

  localparam logic [TOL_W-1:0] TOL_RESET = 15'd102;

  typedef logic [TOL_W-1:0] tol_t;

  typedef struct packed {
    logic signed [PT_W-1:0]   point_x;
    logic signed [PT_W-1:0]   point_y;
    logic signed [LINE_W-1:0] line_slope;
    logic signed [LINE_W-1:0] line_intercept;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic signed [LINE_W-1:0] fit_slope;
    logic signed [LINE_W-1:0] fit_intercept;
    logic                     refined;
    logic [CNT_OUT_W-1:0]     inlier_count;
  } fit_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_CHK, ST_M1, ST_M2, ST_DEN, ST_M3, ST_M4,
    ST_DIV1_GO, ST_DIV1, ST_M5_GO, ST_M5, ST_DIV2_GO, ST_DIV2, ST_KEEP, ST_FIT
  } ilf_state_e;

  typedef enum logic [2:0] {
    MUL_N_SXX, MUL_SX_SX, MUL_N_SXY, MUL_SX_SY, MUL_A_SX
  } mul_sel_e;

  typedef enum logic {
    DIV_SLOPE, DIV_ICPT
  } div_sel_e;

  typedef struct packed {
    logic     take_point;
    logic     accumulate;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_result;
    logic     result_refined;
  } ilf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic last;
    logic n_zero;
    logic den_zero;
    logic out_full;
  } ilf_status_t;

endpackage

// File: design/ilf_chan_if.sv
// valid/ready channel carrying one payload of type T
// no dependencies; payload types come from ilf_pkg at instantiation
interface ilf_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/inlier_gated_line_fit_unit.sv
// top level of the inlier gated least-squares line fit
// depends on ilf_pkg, ilf_chan_if, ilf_ctrl and ilf_datapath
//
//  channel   dir  payload           transfer
//  point_i   in   ilf_pkg::point_t  valid & ready
//  cfg_i     in   ilf_pkg::tol_t    valid & ready (ready always high)
//  fit_o     out  ilf_pkg::fit_t    valid & ready
//
// a point passes through intake with its products, then residual test and sums
// a last point adds the fit: 5 shift-add multiplies of 32 bits and 2 divisions
//   of W+16 bits each (W = 60 at 1024 points), ends early if n or den is zero
// reset clears sums, count, run flag and presets tolerance at once; no clearing pass
// a result waits in the output register while the next run's points are taken;
//   a later fit holds in its final state until that register is free
module inlier_gated_line_fit_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilf_chan_if.sink   point_i,
  ilf_chan_if.sink   cfg_i,
  ilf_chan_if.source fit_o
);
  import ilf_pkg::*;

  ilf_cmd_t    cmd;
  ilf_status_t status;
  logic        point_ready;

  assign point_i.ready = point_ready;
  assign cfg_i.ready   = 1'b1;

  // sequencing
  ilf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .point_valid_i (point_i.valid),
    .point_ready_o (point_ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // arithmetic and storage
  ilf_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .fit_valid_o (fit_o.valid),
    .fit_ready_i (fit_o.ready),
    .fit_o       (fit_o.data)
  );
endmodule

// File: design/ilf_mul.sv
// shift-add signed multiplier, one multiplier bit per cycle
// depends on nothing; product must fit A_W bits
module ilf_mul #(
  parameter int A_W = 60,
  parameter int B_W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [A_W-1:0] a_i,
  input  logic signed [B_W-1:0] b_i,
  output logic                  done_o,
  output logic signed [A_W-1:0] p_o
);
  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   acc_q, a_q, a_mag;
  logic [B_W-1:0]   b_q, b_mag;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q, busy_q, done_q;

  // operand magnitudes
  assign a_mag = a_i[A_W-1] ? -a_i : a_i;
  assign b_mag = b_i[B_W-1] ? -b_i : b_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: add shifted multiplicand per set multiplier bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_mag;
      b_q   <= b_mag;
      neg_q <= a_i[A_W-1] ^ b_i[B_W-1];
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = neg_q ? -acc_q : acc_q;
endmodule

// File: design/ilf_div.sv
// restoring divider giving num*2^16/den truncated, saturated to Q16.16
// depends on ilf_pkg; one quotient bit per cycle
module ilf_div #(
  parameter int N_W = 60
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [N_W-1:0]         num_i,
  input  logic signed [N_W-1:0]         den_i,
  output logic                          done_o,
  output logic signed [ilf_pkg::LINE_W-1:0] q_o
);
  import ilf_pkg::*;

  localparam int DV_W  = N_W + FRAC_SHIFT;
  localparam int CNT_W = $clog2(DV_W + 1);

  logic [DV_W-1:0]   dvd_q;
  logic [N_W-1:0]    ud_q, rem_q, num_mag, den_mag;
  logic [N_W:0]      rem_sh, rem_diff;
  logic              ge;
  logic [LINE_W:0]   q_q, limit, mag;
  logic              ovf_q, neg_q, busy_q, done_q, sat;
  logic [CNT_W-1:0]  cnt_q;

  assign num_mag = num_i[N_W-1] ? -num_i : num_i;
  assign den_mag = den_i[N_W-1] ? -den_i : den_i;

  // one restoring step
  assign rem_sh   = {rem_q, dvd_q[DV_W-1]};
  assign rem_diff = rem_sh - {1'b0, ud_q};
  assign ge       = rem_sh >= {1'b0, ud_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_mag, {FRAC_SHIFT{1'b0}}};
      ud_q  <= den_mag;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[N_W-1] ^ den_i[N_W-1];
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? rem_diff[N_W-1:0] : rem_sh[N_W-1:0];
      q_q   <= {q_q[LINE_W-1:0], ge};
      ovf_q <= ovf_q | q_q[LINE_W];
    end
  end

  // saturate magnitude, then apply sign
  assign limit  = neg_q ? ((LINE_W+1)'(1) << (LINE_W-1))
                        : (((LINE_W+1)'(1) << (LINE_W-1)) - (LINE_W+1)'(1));
  assign sat    = ovf_q || (q_q > limit);
  assign mag    = sat ? limit : q_q;
  assign q_o    = neg_q ? -mag[LINE_W-1:0] : mag[LINE_W-1:0];
  assign done_o = done_q;
endmodule

// File: design/ilf_datapath.sv
// point products, inlier test, running sums, fit operands and result register
// depends on ilf_pkg, ilf_mul, ilf_div and the assertion macro header
`include "inlier_gated_line_fit_unit_macros.svh"

module ilf_datapath #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ilf_pkg::point_t      point_i,
  input  logic                 cfg_valid_i,
  input  ilf_pkg::tol_t        cfg_data_i,
  input  ilf_pkg::ilf_cmd_t    cmd_i,
  output ilf_pkg::ilf_status_t status_o,
  output logic                 fit_valid_o,
  input  logic                 fit_ready_i,
  output ilf_pkg::fit_t        fit_o
);
  import ilf_pkg::*;

  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = PT_W + CW;
  localparam int SQ_W   = SQ_PT_W + CW;
  localparam int WIDE_W = (34 + 2*CW > 49 + CW) ? 34 + 2*CW : 49 + CW;
  localparam int MB_W   = (SUM_W > LINE_W) ? SUM_W : LINE_W;

  tol_t                     tol_q;
  logic                     run_started_q, last_q, out_valid_q;
  logic signed [LINE_W-1:0] held_slope_q, held_icpt_q, slope_sel;
  logic signed [PT_W-1:0]   x_q, y_q;
  logic signed [PAX_W-1:0]  ax_q, ax_w;
  logic signed [SQ_PT_W-1:0] xx_q, xy_q, xx_w, xy_w;
  logic [CW-1:0]            count_q;
  logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
  logic signed [SQ_W-1:0]   sum_xx_q, sum_xy_q;
  logic signed [RES_W-1:0]  resid;
  logic [RES_W-1:0]         resid_mag, tol_lim;
  logic                     is_inlier;
  logic signed [WIDE_W-1:0] prod_q, den_q, num_q, n_wide;
  logic signed [WIDE_W-1:0] mul_a, mul_p, div_den;
  logic signed [MB_W-1:0]   mul_b;
  logic                     mul_done, div_done;
  logic signed [LINE_W-1:0] div_q, slope_q, icpt_q;
  mul_sel_e                 mul_sel_q;
  div_sel_e                 div_sel_q;
  fit_t                     out_q;

  // point products, using the held line once the run has started
  assign slope_sel = run_started_q ? held_slope_q : point_i.line_slope;
  assign ax_w      = slope_sel * point_i.point_x;
  assign xx_w      = point_i.point_x * point_i.point_x;
  assign xy_w      = point_i.point_x * point_i.point_y;

  // residual a*x - y + b in Q.28 against the tolerance
  assign resid     = RES_W'(ax_q) - (RES_W'(y_q) <<< FRAC_SHIFT)
                   + (RES_W'(held_icpt_q) <<< ICPT_SHIFT);
  assign resid_mag = resid[RES_W-1] ? -resid : resid;
  assign tol_lim   = RES_W'({tol_q, {FRAC_SHIFT{1'b0}}});
  assign is_inlier = (resid_mag < tol_lim) && (count_q < CW'(MAX_POINTS));

  assign n_wide = WIDE_W'(count_q);

  // multiplier operand selection, sampled by the multiplier at its start
  always_comb begin
    mul_a = WIDE_W'(sum_x_q);
    mul_b = MB_W'(sum_x_q);
    case (cmd_i.mul_sel)
      MUL_N_SXX: begin
        mul_a = WIDE_W'(sum_xx_q);
        mul_b = MB_W'(n_wide);
      end
      MUL_SX_SX: begin
        mul_a = WIDE_W'(sum_x_q);
        mul_b = MB_W'(sum_x_q);
      end
      MUL_N_SXY: begin
        mul_a = WIDE_W'(sum_xy_q);
        mul_b = MB_W'(n_wide);
      end
      MUL_SX_SY: begin
        mul_a = WIDE_W'(sum_y_q);
        mul_b = MB_W'(sum_x_q);
      end
      MUL_A_SX: begin
        mul_a = WIDE_W'(sum_x_q);
        mul_b = MB_W'(slope_q);
      end
      default: begin
        mul_a = WIDE_W'(sum_x_q);
        mul_b = MB_W'(sum_x_q);
      end
    endcase
  end

  // divisor: fit denominator or n scaled to Q.28, sampled at the divider start
  assign div_den = (cmd_i.div_sel == DIV_SLOPE) ? den_q : (n_wide <<< N_SHIFT);

  ilf_mul #(.A_W(WIDE_W), .B_W(MB_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  ilf_div #(.N_W(WIDE_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // control state: tolerance, run flags, count, sums, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q         <= TOL_RESET;
      run_started_q <= 1'b0;
      count_q       <= '0;
      sum_x_q       <= '0;
      sum_y_q       <= '0;
      sum_xx_q      <= '0;
      sum_xy_q      <= '0;
      held_slope_q  <= '0;
      held_icpt_q   <= '0;
      out_valid_q   <= 1'b0;
      mul_sel_q     <= MUL_N_SXX;
      div_sel_q     <= DIV_SLOPE;
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      if (cmd_i.take_point && !run_started_q) begin
        held_slope_q  <= point_i.line_slope;
        held_icpt_q   <= point_i.line_intercept;
        run_started_q <= 1'b1;
      end
      if (cmd_i.accumulate && is_inlier) begin
        sum_x_q  <= sum_x_q + SUM_W'(x_q);
        sum_y_q  <= sum_y_q + SUM_W'(y_q);
        sum_xx_q <= sum_xx_q + SQ_W'(xx_q);
        sum_xy_q <= sum_xy_q + SQ_W'(xy_q);
        count_q  <= count_q + 1'b1;
      end
      if (cmd_i.mul_start) begin
        mul_sel_q <= cmd_i.mul_sel;
      end
      if (cmd_i.div_start) begin
        div_sel_q <= cmd_i.div_sel;
      end
      // result register; the run is cleared as its result is loaded
      if (cmd_i.load_result) begin
        out_valid_q   <= 1'b1;
        run_started_q <= 1'b0;
        count_q       <= '0;
        sum_x_q       <= '0;
        sum_y_q       <= '0;
        sum_xx_q      <= '0;
        sum_xy_q      <= '0;
      end else if (out_valid_q && fit_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_point) begin
      x_q    <= point_i.point_x;
      y_q    <= point_i.point_y;
      ax_q   <= ax_w;
      xx_q   <= xx_w;
      xy_q   <= xy_w;
      last_q <= point_i.last_point;
    end
    // capture products and form numerator and denominator
    if (mul_done) begin
      case (mul_sel_q)
        MUL_N_SXX: prod_q <= mul_p;
        MUL_SX_SX: den_q  <= prod_q - mul_p;
        MUL_N_SXY: prod_q <= mul_p;
        MUL_SX_SY: num_q  <= prod_q - mul_p;
        MUL_A_SX:  num_q  <= (WIDE_W'(sum_y_q) <<< FRAC_SHIFT) - mul_p;
        default:   prod_q <= mul_p;
      endcase
    end
    if (div_done) begin
      if (div_sel_q == DIV_SLOPE) begin
        slope_q <= div_q;
      end else begin
        icpt_q <= div_q;
      end
    end
    if (cmd_i.load_result) begin
      out_q.fit_slope     <= cmd_i.result_refined ? slope_q : held_slope_q;
      out_q.fit_intercept <= cmd_i.result_refined ? icpt_q : held_icpt_q;
      out_q.refined       <= cmd_i.result_refined;
      out_q.inlier_count  <= CNT_OUT_W'(count_q);
    end
  end

  assign status_o.mul_done = mul_done;
  assign status_o.div_done = div_done;
  assign status_o.last     = last_q;
  assign status_o.n_zero   = (count_q == '0);
  assign status_o.den_zero = (den_q == '0);
  assign status_o.out_full = out_valid_q;

  assign fit_valid_o = out_valid_q;
  assign fit_o       = out_q;

  // checks
  `ILF_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(MAX_POINTS), "inlier count above limit")
  `ILF_ASSERT_NOW(a_den_nonzero, clk_i, rst_ni, cmd_i.div_start && cmd_i.div_sel == DIV_SLOPE, den_q != '0, "slope division with zero denominator")
  `ILF_ASSERT_NOW(a_load_free, clk_i, rst_ni, cmd_i.load_result, !out_valid_q, "result loaded over a pending result")
  `ILF_ASSERT_NEXT(a_run_cleared, clk_i, rst_ni, cmd_i.load_result, count_q == '0 && !run_started_q, "run not cleared after result")
endmodule

// File: design/ilf_ctrl.sv
// controller state machine sequencing point intake and the final fit
// depends on ilf_pkg; drives the datapath through command signals
module ilf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 point_valid_i,
  output logic                 point_ready_o,
  input  ilf_pkg::ilf_status_t status_i,
  output ilf_pkg::ilf_cmd_t    cmd_o
);
  import ilf_pkg::*;

  ilf_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d              = state_q;
    point_ready_o        = 1'b0;
    cmd_o.take_point     = 1'b0;
    cmd_o.accumulate     = 1'b0;
    cmd_o.mul_start      = 1'b0;
    cmd_o.mul_sel        = MUL_N_SXX;
    cmd_o.div_start      = 1'b0;
    cmd_o.div_sel        = DIV_SLOPE;
    cmd_o.load_result    = 1'b0;
    cmd_o.result_refined = 1'b0;
    case (state_q)
      ST_IDLE: begin
        point_ready_o = 1'b1;
        if (point_valid_i) begin
          cmd_o.take_point = 1'b1;
          state_d          = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d          = status_i.last ? ST_CHK : ST_IDLE;
      end
      ST_CHK: begin
        if (status_i.n_zero) begin
          state_d = ST_KEEP;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_N_SXX;
          state_d         = ST_M1;
        end
      end
      ST_M1: begin
        if (status_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_SX_SX;
          state_d         = ST_M2;
        end
      end
      ST_M2: begin
        if (status_i.mul_done) begin
          state_d = ST_DEN;
        end
      end
      ST_DEN: begin
        if (status_i.den_zero) begin
          state_d = ST_KEEP;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_N_SXY;
          state_d         = ST_M3;
        end
      end
      ST_M3: begin
        if (status_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_SX_SY;
          state_d         = ST_M4;
        end
      end
      ST_M4: begin
        if (status_i.mul_done) begin
          state_d = ST_DIV1_GO;
        end
      end
      ST_DIV1_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SLOPE;
        state_d         = ST_DIV1;
      end
      ST_DIV1: begin
        if (status_i.div_done) begin
          state_d = ST_M5_GO;
        end
      end
      ST_M5_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_A_SX;
        state_d         = ST_M5;
      end
      ST_M5: begin
        if (status_i.mul_done) begin
          state_d = ST_DIV2_GO;
        end
      end
      ST_DIV2_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ICPT;
        state_d         = ST_DIV2;
      end
      ST_DIV2: begin
        if (status_i.div_done) begin
          state_d = ST_FIT;
        end
      end
      ST_KEEP: begin
        if (!status_i.out_full) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_FIT: begin
        if (!status_i.out_full) begin
          cmd_o.load_result    = 1'b1;
          cmd_o.result_refined = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule

// File: tb/testbench.sv
// self-checking testbench for the inlier gated least-squares line fit unit
// depends on ilf_pkg, ilf_chan_if and inlier_gated_line_fit_unit
`timescale 1ns / 1ps

module testbench;
  import ilf_pkg::*;

  localparam int  MAX_PTS    = 1024;
  localparam int  SETTLE     = 400;
  localparam longint LIMIT   = 3000000;
  localparam int  PT_BITS    = $bits(point_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int points_sent = 0;

  ilf_chan_if #(.T(point_t)) point_ch ();
  ilf_chan_if #(.T(tol_t))   cfg_ch ();
  ilf_chan_if #(.T(fit_t))   fit_ch ();

  inlier_gated_line_fit_unit #(.MAX_POINTS(MAX_PTS)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_ch.sink),
    .cfg_i   (cfg_ch.sink),
    .fit_o   (fit_ch.source)
  );

  // line fit predictor and queue of expected fits
  class fit_scoreboard;
    tol_t   tol = TOL_RESET;
    int     n_in = 0;
    longint sx = 0, sy = 0, sxx = 0, sxy = 0;
    longint a_held = 0, b_held = 0;
    bit     in_run = 0;
    fit_t   pending_fits[$];
    int     errors = 0;
    int     fits_seen = 0;
    int     refined_seen = 0;

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // num * 2^16 / den, truncated toward zero, saturated to 32 bits
    function logic [31:0] q16_quot(longint num, longint den);
      bit neg;
      logic [127:0] un, ud, mag, lim;
      neg = (num < 0) != (den < 0);
      un  = num < 0 ? 128'(-num) : 128'(num);
      ud  = den < 0 ? 128'(-den) : 128'(den);
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (un / ud > 32768) mag = lim;
      else begin
        mag = (un << 16) / ud;
        if (mag > lim) mag = lim;
      end
      return neg ? 32'(-mag) : 32'(mag);
    endfunction

    function void note_point(point_t p);
      longint x, y, r, n, den;
      logic [31:0] s_out, b_out;
      bit ref_ok;
      fit_t f;
      x = longint'(p.point_x);
      y = longint'(p.point_y);
      if (!in_run) begin
        a_held = longint'(p.line_slope);
        b_held = longint'(p.line_intercept);
        in_run = 1;
      end
      r = a_held * x - y * 65536 + b_held * 4096;
      if (r < 0) r = -r;
      if (r < (longint'(tol) << 16) && n_in < MAX_PTS) begin
        sx += x; sy += y; sxx += x * x; sxy += x * y; n_in++;
      end
      if (!p.last_point) return;
      s_out  = 32'(a_held);
      b_out  = 32'(b_held);
      ref_ok = 0;
      if (n_in > 0) begin
        n   = n_in;
        den = n * sxx - sx * sx;
        if (den != 0) begin
          s_out  = q16_quot(n * sxy - sx * sy, den);
          b_out  = q16_quot(sy * 65536 - longint'($signed(s_out)) * sx, n << 28);
          ref_ok = 1;
        end
      end
      f.fit_slope     = s_out;
      f.fit_intercept = b_out;
      f.refined       = ref_ok;
      f.inlier_count  = 11'(n_in);
      pending_fits.push_back(f);
      n_in = 0; sx = 0; sy = 0; sxx = 0; sxy = 0; in_run = 0;
    endfunction

    task check_fit(fit_t got);
      fit_t w;
      fits_seen++;
      if (got.refined) refined_seen++;
      if (pending_fits.size() == 0) begin
        report_mismatch("fit transfer with nothing expected");
        return;
      end
      w = pending_fits.pop_front();
      if (got.fit_slope !== w.fit_slope)
        report_mismatch($sformatf("slope %h, want %h", got.fit_slope, w.fit_slope));
      if (got.fit_intercept !== w.fit_intercept)
        report_mismatch($sformatf("intercept %h, want %h",
                                  got.fit_intercept, w.fit_intercept));
      if (got.refined !== w.refined)
        report_mismatch($sformatf("refined %b, want %b", got.refined, w.refined));
      if (got.inlier_count !== w.inlier_count)
        report_mismatch($sformatf("count %0d, want %0d",
                                  got.inlier_count, w.inlier_count));
    endtask
  endclass

  fit_scoreboard sb = new();

  // clock and cycle limit
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("inlier_gated_line_fit_unit regression: fail");
      $finish;
    end
  end

  // receiver with random stalls, fit transfers checked
  initial fit_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni && fit_ch.valid && fit_ch.ready) sb.check_fit(fit_ch.data);
    fit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_point(point_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      point_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    point_ch.valid <= 1'b1;
    point_ch.data  <= p;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
    sb.note_point(p);
    points_sent++;
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    while (sb.pending_fits.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_tol(tol_t t);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= t;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    sb.tol = t;
    @(posedge clk_i);
  endtask

  function automatic point_t mk(int x, int y, int a, int b, bit last);
    point_t p;
    p.point_x = 16'(x); p.point_y = 16'(y);
    p.line_slope = 32'(a); p.line_intercept = 32'(b);
    p.last_point = last;
    return p;
  endfunction

  // run of points near a random line, noise scaled to the tolerance
  task automatic send_line_run(int len);
    int a, b, x, y, nz;
    a  = $urandom_range(262144) - 131072;
    b  = $urandom_range(131072) - 65536;
    nz = (int'(sb.tol) * 3) / 2 + 2;
    for (int i = 0; i < len; i++) begin
      x = $urandom_range(16000) - 8000;
      y = int'((longint'(a) * x) >>> 16) + (b >>> 4)
          + int'($urandom_range(2 * nz)) - nz;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      send_point(mk(x, y, a, b, i == len - 1));
    end
  endtask

  task automatic send_noise();
    point_t p;
    p = point_t'(PT_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    p.last_point = ($urandom_range(7) == 0);
    send_point(p);
  endtask

  initial begin
    int pct_send[4];
    int pct_recv[4];
    tol_t tols[4];
    pct_send = '{0, 78, 0, 38};
    pct_recv = '{0, 0, 78, 38};
    point_ch.valid = 1'b0;
    point_ch.data  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset tolerance, one-point run has a zero denominator
    send_point(mk(0, 0, 0, 0, 1));
    send_point(mk(32767, -32768, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_point(mk(-32768, 32767, 0, 0, 1));
    drain();
    write_tol(15'h7FFF);
    // equal x everywhere: zero denominator with inliers
    send_point(mk(100, 5, 0, 0, 0));
    send_point(mk(100, -7, 32'h7FFF_FFFF, 5, 0));
    send_point(mk(100, 9, 0, 0, 1));
    // steep data saturates the slope
    send_point(mk(0, -30000, 0, 0, 0));
    send_point(mk(1, 30000, 0, 0, 1));
    send_point(mk(1, -30000, 0, 0, 0));
    send_point(mk(0, 30000, 0, 0, 1));
    // extremes of the point fields, y at its minimum never passes
    send_point(mk(-32768, -32768, 0, 0, 0));
    send_point(mk(32767, 32767, 0, 0, 0));
    send_point(mk(-32768, 0, 0, 0, 0));
    send_point(mk(32767, -1, 0, 0, 1));
    send_point(mk(-32768, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    // more inliers than the count can hold
    for (int i = 0; i < MAX_PTS + 40; i++)
      send_point(mk($urandom_range(4000) - 2000, $urandom_range(8000) - 4000,
                    0, 0, i == MAX_PTS + 39));
    drain();
    write_tol(15'd0);
    send_point(mk(1, 2, 0, 0, 0));
    send_point(mk(3, 4, 0, 0, 1));
    drain();

    // random phases, tolerance changed only while idle
    tols = '{TOL_RESET, 15'd0, 15'($urandom_range(400, 20)), 15'h7FFF};
    for (int ph = 0; ph < 4; ph++) begin
      write_tol(tols[ph]);
      send_idle_pct  = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int k = 0; k < 27; k++) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_line_run($urandom_range(6, 1));
        if (ph == 1 && k == 13) drain();
      end
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();

    $display("sent %0d points over four stall phases and several tolerances", points_sent);
    $display("checked %0d fits, %0d of them refined", sb.fits_seen, sb.refined_seen);
    if (sb.pending_fits.size() != 0)
      sb.report_mismatch($sformatf("%0d fits never arrived", sb.pending_fits.size()));
    if (sb.errors == 0) begin
      $display("inlier_gated_line_fit_unit regression: pass");
    end else begin
      $display("inlier_gated_line_fit_unit regression: fail");
    end
    $finish;
  end
endmodule

// File: inlier_gated_line_fit_unit.f
+incdir+design
design/ilf_pkg.sv
design/ilf_chan_if.sv
design/ilf_mul.sv
design/ilf_div.sv
design/ilf_datapath.sv
design/ilf_ctrl.sv
design/inlier_gated_line_fit_unit.sv
tb/testbench.sv
